// ----- src/binary_to_decimal_digits_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the binary to decimal digit converter
// Short forms for clocked, reset-qualified implications on the port signals.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_DIGITS_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define BTD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define BTD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/btd_pkg.sv -----
// ---------------------------------------------------------------------------
// btd_pkg
// Types, constants and helper functions of the binary to decimal converter.
// ---------------------------------------------------------------------------
`default_nettype none

package btd_pkg;

  localparam int VALUE_W        = 20;
  localparam int DIGIT_W        = 4;
  localparam int NUM_DIGITS_DEF = 6;
  localparam int NUM_DIGITS_MAX = 9;
  // Wide enough for 10^9, the limit at the largest digit count.
  localparam int WEIGHT_W       = 34;
  localparam int EXP_W          = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // One queued item: the value and its range class.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               too_large;
  } btd_entry_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic       valid;
    btd_entry_t entry;
  } btd_head_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rem;
  } btd_step_t;

  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [EXP_W-1:0] e);
    logic [WEIGHT_W-1:0] w;
    case (e)
      4'd0:    w = WEIGHT_W'(64'd1);
      4'd1:    w = WEIGHT_W'(64'd10);
      4'd2:    w = WEIGHT_W'(64'd100);
      4'd3:    w = WEIGHT_W'(64'd1000);
      4'd4:    w = WEIGHT_W'(64'd10000);
      4'd5:    w = WEIGHT_W'(64'd100000);
      4'd6:    w = WEIGHT_W'(64'd1000000);
      4'd7:    w = WEIGHT_W'(64'd10000000);
      4'd8:    w = WEIGHT_W'(64'd100000000);
      4'd9:    w = WEIGHT_W'(64'd1000000000);
      default: w = '0;
    endcase
    return w;
  endfunction

  // Leading digit of v against weight w, found by nine parallel compares
  // against the multiples of w, and what is left once it is taken off.
  function automatic btd_step_t digit_step(input logic [VALUE_W-1:0] v,
                                           input logic [WEIGHT_W-1:0] w);
    btd_step_t           s;
    logic [WEIGHT_W-1:0] vx;
    logic [WEIGHT_W-1:0] mw;
    logic [WEIGHT_W-1:0] sub;
    vx      = WEIGHT_W'(v);
    sub     = '0;
    s.digit = '0;
    for (int m = 1; m <= 9; m++) begin
      mw = WEIGHT_W'(m) * w;
      if (vx >= mw) begin
        s.digit = DIGIT_W'(m);
        sub     = mw;
      end
    end
    s.rem = VALUE_W'(vx - sub);
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/btd_front.sv -----
// ---------------------------------------------------------------------------
// btd_front
// Accepts input items, flags values out of range and queues them.
// ---------------------------------------------------------------------------
`default_nettype none

module btd_front
  import btd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               pop,
  output btd_head_t               head
);

  localparam logic [WEIGHT_W-1:0] LIMIT = weight_of(EXP_W'(NUM_DIGITS));

  btd_entry_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push;
  logic               pop_ok;
  btd_entry_t         wr_entry;

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop_ok    = pop && (count_r != '0);

  always_comb begin
    wr_entry.value     = in_value;
    wr_entry.too_large = (WEIGHT_W'(in_value) >= LIMIT);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- src/btd_back.sv -----
// ---------------------------------------------------------------------------
// btd_back
// Splits queued values into decimal digits, one result item per cycle while the receiver takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module btd_back
  import btd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire btd_head_t          head,
  output logic                    pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [DIGIT_W-1:0]      out_digit,
  output logic                    out_is_last,
  output logic                    out_too_large
);

  localparam int CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic                busy_r, busy_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]  rem_r, rem_nxt;
  logic                valid_r, valid_nxt;
  logic [DIGIT_W-1:0]  digit_r, digit_nxt;
  logic                last_r, last_nxt;
  logic                err_r, err_nxt;

  logic                advance;
  logic [VALUE_W-1:0]  src_value;
  logic [CNT_W-1:0]    src_cnt;
  logic                src_last;
  logic [EXP_W-1:0]    src_exp;
  btd_step_t           step;

  // The output register is free when empty or being taken this cycle.
  assign advance   = !valid_r || out_tready;
  assign src_value = busy_r ? rem_r : head.entry.value;
  assign src_cnt   = busy_r ? cnt_r : '0;
  assign src_last  = (src_cnt == CNT_W'(NUM_DIGITS - 1));
  assign src_exp   = EXP_W'(NUM_DIGITS - 1) - EXP_W'(src_cnt);
  assign step      = digit_step(src_value, weight_of(src_exp));
  assign pop       = advance && !busy_r && head.valid;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    valid_nxt = valid_r;
    digit_nxt = digit_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    if (advance) begin
      valid_nxt = busy_r || head.valid;
      if (!busy_r && head.valid && head.entry.too_large) begin
        digit_nxt = '0;
        last_nxt  = 1'b1;
        err_nxt   = 1'b1;
      end else if (busy_r || head.valid) begin
        digit_nxt = step.digit;
        last_nxt  = src_last;
        err_nxt   = 1'b0;
        rem_nxt   = step.rem;
        cnt_nxt   = src_cnt + 1'b1;
        busy_nxt  = !src_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    digit_r <= digit_nxt;
    last_r  <= last_nxt;
    err_r   <= err_nxt;
  end

  assign out_tvalid    = valid_r;
  assign out_digit     = digit_r;
  assign out_is_last   = last_r;
  assign out_too_large = err_r;

endmodule

`default_nettype wire

// ----- src/binary_to_decimal_digits.sv -----
// ---------------------------------------------------------------------------
// binary_to_decimal_digits
// Converts unsigned binary values into runs of decimal digits.
// ---------------------------------------------------------------------------
// Each input item on the in_ stream carries one 20-bit unsigned value. The
// out_ stream answers with NUM_DIGITS result items, one digit each, most
// significant first with leading zeros kept; out_tlast marks the final one.
// A value of 10^NUM_DIGITS or more gives a single item with out_tuser set,
// digit zero and out_tlast set.
// The first digit passes through the queue and then the output register
// before it is presented on out_.
// The back end emits one result item per cycle while the receiver takes
// them, so a value gives NUM_DIGITS items (six by default) and a refused
// value gives one. A two-entry queue between the front and the back end lets
// new items in while a run is still being emitted.
// Reset empties the queue and the output register. When the receiver stalls,
// the current item holds on out_ and the queue fills, after which in_tready
// falls until the receiver takes items again.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_digits
  import btd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [19:0] value, [23:20] zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [3:0] digit, [7:4] zero fill
  output logic             out_tlast,
  output logic             out_tuser   // [0] too_large
);

  btd_head_t          head;
  logic               pop;
  logic [DIGIT_W-1:0] digit;

  btd_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata[VALUE_W-1:0]),
    .pop       (pop),
    .head      (head)
  );

  btd_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_digit     (digit),
    .out_is_last   (out_tlast),
    .out_too_large (out_tuser)
  );

  assign out_tdata = {4'b0000, digit};

endmodule

`default_nettype wire

// ----- src/btd_checker.sv -----
// ---------------------------------------------------------------------------
// btd_checker
// Port-level checks on the result stream of the decimal digit converter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_digits_macros.svh"

module btd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic       out_tuser
);

  // A refused value is a run of one item with a zero digit.
  `BTD_ASSERT_NOW(a_err_alone, out_tvalid && out_tuser, out_tlast && (out_tdata == 8'd0), "too-large item is not a lone zero item")

  // Every digit is a decimal digit and the fill bits stay zero.
  `BTD_ASSERT_NOW(a_digit_range, out_tvalid, (out_tdata[7:4] == 4'd0) && (out_tdata[3:0] <= 4'd9), "digit out of range")

  // A stalled item holds its contents.
  `BTD_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result item changed")

endmodule

bind binary_to_decimal_digits btd_checker u_btd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
